[rtl/vscm_pkg.sv]
package vscm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_EXAMINE = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_TRI    = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_COLS      = 2'd2;
  localparam logic [1:0] REG_SLICES    = 2'd3;

  localparam logic [15:0] THRESHOLD_RST = 16'd58982;
  localparam logic [6:0]  EXTENT_RST    = 7'd64;

  localparam int          VC_W         = 22;
  localparam int          VT_W         = 16;
  localparam int          COORD_W      = 18;
  localparam logic [9:0]  COORD_SCALE  = 10'd11;
  localparam logic [9:0]  CORNER_STEP  = 10'd10;
  localparam logic [25:0] ROUND_BIAS   = 26'd500;
  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for x below 2^26
  localparam logic [26:0] RECIP        = 27'd68719477;
  localparam int          RECIP_SHIFT  = 36;

  localparam logic [4:0] VERTS_LAST = 5'd7;
  localparam logic [4:0] EMIT_LAST  = 5'd19;
  localparam logic [2:0] MUL_COUNT  = 3'd6;

  localparam logic [3:0] CUBE_TRIS [12][3] = '{
    '{4'd1, 4'd2, 4'd3}, '{4'd2, 4'd4, 4'd3}, '{4'd3, 4'd4, 4'd7},
    '{4'd4, 4'd8, 4'd7}, '{4'd1, 4'd3, 4'd7}, '{4'd1, 4'd7, 4'd5},
    '{4'd1, 4'd6, 4'd2}, '{4'd1, 4'd5, 4'd6}, '{4'd7, 4'd8, 4'd6},
    '{4'd7, 4'd6, 4'd5}, '{4'd2, 4'd8, 4'd4}, '{4'd2, 4'd6, 4'd8}
  };

endpackage

[rtl/voxel_surface_cube_mesher.sv]
// Write and restart items are taken in the idle state and leave the block idle.
// Examine: 27 neighbor reads, one per cycle from the bitmap's read port, then a wait
// state lets the last read settle the neighborhood flags before the emit state loads
// the output register; then up to 20 results (one for a non-surface voxel) at one per
// cycle while m_tready is high. No new item is accepted until the last result is loaded.
// Reset clears control state, the vertex counter and the configuration registers; the bitmap is
// not cleared and holds garbage until written.
module voxel_surface_cube_mesher #(
  parameter int EDGE_MAX = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // row[5:0], col[11:6], slice[17:12], sample[33:18]
  input  logic [1:0]   s_tuser,   // operation[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // vx[17:0], vy[35:18], vz[53:36], tri_a[75:54],
                                  // tri_b[97:76], tri_c[119:98]
  output logic [1:0]   m_tuser,   // kind[1:0]
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import vscm_pkg::*;

  localparam int          EW       = $clog2(EDGE_MAX);
  localparam int          AW       = 3 * EW;
  localparam int          DEPTH    = 1 << AW;
  localparam logic [8:0]  EDGE_LIM = 9'(EDGE_MAX);

  state_t state, state_next;

  logic [15:0] threshold;
  logic [6:0]  rows_reg, cols_reg, slices_reg;
  logic [6:0]  lim_r, lim_c, lim_s;

  logic [5:0]  in_row, in_col, in_slice;
  logic [15:0] in_sample;
  logic        in_accept;

  logic          mem [DEPTH];
  logic          wr_en, wr_bit;
  logic [AW-1:0] wr_addr;
  logic          rd_en, rd_bit;
  logic [AW-1:0] rd_addr;

  logic [5:0] br, bs, bc;
  logic [1:0] dr, ds, dc;
  logic [6:0] nr, ns, nc;
  logic       n_inv, scan_last;
  logic       rd_valid, rd_inv, rd_ctr;
  logic       all_set, center, surface;

  logic [2:0]      msel, psel;
  logic            pvalid;
  logic [5:0]      mul_coord;
  logic [9:0]      mul_num;
  logic [25:0]     mul_x;
  logic [52:0]     prod;
  logic [VT_W-1:0] vt [6];

  logic [4:0]      ecnt;
  logic [3:0]      tri_t;
  logic            load, emit_last;
  logic [VC_W-1:0] vcount;

  logic [COORD_W-1:0] o_vx, o_vy, o_vz;
  logic [VC_W-1:0]    o_ta, o_tb, o_tc;
  logic [1:0]         o_kind;
  logic               o_last;

  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[11:6];
  assign in_slice  = s_tdata[17:12];
  assign in_sample = s_tdata[33:18];
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign lim_r = ({2'b0, rows_reg}   > EDGE_LIM) ? EDGE_LIM[6:0] : rows_reg;
  assign lim_c = ({2'b0, cols_reg}   > EDGE_LIM) ? EDGE_LIM[6:0] : cols_reg;
  assign lim_s = ({2'b0, slices_reg} > EDGE_LIM) ? EDGE_LIM[6:0] : slices_reg;

  assign wr_en   = in_accept && (s_tuser == OP_WRITE) && ({1'b0, in_row} < lim_r) &&
                   ({1'b0, in_slice} < lim_s) && ({1'b0, in_col} < lim_c);
  assign wr_bit  = in_sample > threshold;
  assign wr_addr = {EW'(in_row), EW'(in_slice), EW'(in_col)};

  // neighbor coordinates carry a +1 bias so that -1 shows as zero
  assign nr    = {1'b0, br} + {5'b0, dr};
  assign ns    = {1'b0, bs} + {5'b0, ds};
  assign nc    = {1'b0, bc} + {5'b0, dc};
  assign n_inv = (nr != 7'd0) && (nr <= lim_r) && (ns != 7'd0) && (ns <= lim_s) &&
                 (nc != 7'd0) && (nc <= lim_c);
  assign rd_addr   = {EW'(nr - 7'd1), EW'(ns - 7'd1), EW'(nc - 7'd1)};
  assign rd_en     = (state == ST_SCAN);
  assign scan_last = (dr == 2'd2) && (ds == 2'd2) && (dc == 2'd2);

  assign surface   = center && !all_set;
  assign emit_last = !surface || (ecnt == EMIT_LAST);
  assign tri_t     = 4'(ecnt - 5'd8);

  assign mul_coord = msel[2] ? bc : (msel[1] ? bs : br);
  assign mul_num   = ({4'b0, mul_coord} * COORD_SCALE) + (msel[0] ? CORNER_STEP : 10'd0);
  assign mul_x     = {mul_num, 16'd0} + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tuser == OP_EXAMINE) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        load = !m_tvalid || m_tready;
        if (load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      rows_reg   <= EXTENT_RST;
      cols_reg   <= EXTENT_RST;
      slices_reg <= EXTENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data;
        REG_ROWS:      rows_reg   <= cfg_data[6:0];
        REG_COLS:      cols_reg   <= cfg_data[6:0];
        REG_SLICES:    slices_reg <= cfg_data[6:0];
        default:       threshold  <= threshold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      pvalid   <= 1'b0;
      msel     <= MUL_COUNT;
      vcount   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      rd_inv   <= n_inv;
      rd_ctr   <= (dr == 2'd1) && (ds == 2'd1) && (dc == 2'd1);

      if (in_accept && s_tuser == OP_EXAMINE) begin
        br      <= in_row;
        bs      <= in_slice;
        bc      <= in_col;
        dr      <= 2'd0;
        ds      <= 2'd0;
        dc      <= 2'd0;
        all_set <= 1'b1;
        center  <= 1'b0;
        msel    <= '0;
        ecnt    <= '0;
      end else begin
        if (rd_en) begin
          if (dc == 2'd2) begin
            dc <= 2'd0;
            if (ds == 2'd2) begin
              ds <= 2'd0;
              dr <= dr + 2'd1;
            end else begin
              ds <= ds + 2'd1;
            end
          end else begin
            dc <= dc + 2'd1;
          end
        end
        if (rd_valid) begin
          all_set <= all_set & rd_inv & rd_bit;
          if (rd_ctr) begin
            center <= rd_inv & rd_bit;
          end
        end
        if (rd_en && msel != MUL_COUNT) begin
          msel <= msel + 3'd1;
        end
        if (load) begin
          ecnt <= ecnt + 5'd1;
        end
      end

      pvalid <= rd_en && (msel != MUL_COUNT);
      psel   <= msel;
      prod   <= {27'b0, mul_x} * {26'b0, RECIP};
      if (pvalid) begin
        vt[psel] <= prod[RECIP_SHIFT +: VT_W];
      end

      if (in_accept && s_tuser == OP_RESTART) begin
        vcount <= '0;
      end else if (load && surface && ecnt == EMIT_LAST) begin
        vcount <= vcount + VC_W'(8);
      end

      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_vx <= '0;
      o_vy <= '0;
      o_vz <= '0;
      o_ta <= '0;
      o_tb <= '0;
      o_tc <= '0;
      if (!surface) begin
        o_kind <= KIND_NONE;
        o_last <= 1'b1;
      end else if (ecnt <= VERTS_LAST) begin
        o_kind <= KIND_VERTEX;
        o_last <= 1'b0;
        o_vx   <= {2'b0, (ecnt[2] ? vt[1] : vt[0])};
        o_vy   <= {2'b0, (ecnt[1] ? vt[3] : vt[2])};
        o_vz   <= {2'b0, (ecnt[0] ? vt[5] : vt[4])};
      end else begin
        o_kind <= KIND_TRI;
        o_last <= (ecnt == EMIT_LAST);
        o_ta   <= vcount + VC_W'(CUBE_TRIS[tri_t][0]);
        o_tb   <= vcount + VC_W'(CUBE_TRIS[tri_t][1]);
        o_tc   <= vcount + VC_W'(CUBE_TRIS[tri_t][2]);
      end
    end
  end

  assign m_tdata = {o_tc, o_tb, o_ta, o_vz, o_vy, o_vx};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_SCAN) || (state == ST_WAIT))
    else $error("bitmap data returned outside a neighborhood scan");

  a_vertices_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (msel == MUL_COUNT) && !pvalid)
    else $error("emission started before all vertex coordinates were stored");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (load && surface && ecnt == EMIT_LAST) |=> vcount == $past(vcount) + VC_W'(8))
    else $error("vertex counter did not advance by one cube");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_NONE) |-> m_tlast && (m_tdata == '0))
    else $error("empty result carries data or lacks last");

endmodule
